// File: hw/rtl/lpbi_pkg.sv
// lpbi_pkg: shared types and constants for the longest positive-balance interval block
// beat structs for the sample and result channels, default sizes and register reset
// no dependencies
package lpbi_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 11;

    // default sequence length limit
    localparam int MAX_LEN_DEF = 1024;

    // threshold register reset value
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd8;

    // sample channel beat
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } in_beat_t;

    // result channel beat
    typedef struct packed {
        logic [LEN_W-1:0] best_length;
        logic             last_out;
        logic             overflow;
    } out_beat_t;

endpackage

// File: hw/rtl/longest_positive_balance_interval.sv
// longest_positive_balance_interval: streaming longest positive-sum interval over +1/-1 samples
// depends on lpbi_pkg and lpbi_ram
//
// Usage:
//   Samples arrive on the s_ channel (valid/ready), one sample and a last flag per beat.
//   Each sample above the threshold counts +1, any other sample -1. For every sample
//   one result beat leaves on the m_ channel with the longest positive-sum interval
//   length so far, the echoed last flag and an overflow flag for samples beyond MAX_LEN.
//   The threshold is written on the cfg_ channel, always ready; the user must write it
//   only while idle, the block itself does not enforce this. Throughput: one sample per
//   cycle while results are taken; the first-position table is read at balance-1
//   and written at the new depth in the same cycle on separate ports of one ram, and
//   the best length is updated in the stage after the registered ram read.
//   Seen entries are tracked by a depth count and a zero-balance flag, so a sequence
//   end or reset needs no clearing pass; the next sample is taken right away.
//   Reset empties the pipeline, zeroes balance, position and best length and sets the
//   threshold to 8. When the receiver stalls, the result is held in the output register
//   and one more sample can sit in the lookup stage; after that s_ready drops.
module longest_positive_balance_interval #(
    parameter int MAX_LEN = lpbi_pkg::MAX_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lpbi_pkg::in_beat_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lpbi_pkg::out_beat_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lpbi_pkg::SAMPLE_W-1:0] cfg_data
);

    // counter/index width holds 0..MAX_LEN, table entries hold positions below MAX_LEN
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int FP_W  = $clog2(MAX_LEN);
    localparam int BAL_W = CNT_W + 1;
    localparam int DEPTH = MAX_LEN + 1;

    // lookup stage contents
    typedef struct packed {
        logic [CNT_W-1:0] here;
        logic             positive;
        logic             lookup;
        logic             overflow;
        logic             last;
    } stage_t;

    // registers
    logic [lpbi_pkg::SAMPLE_W-1:0] threshold_reg;
    logic signed [BAL_W-1:0]       balance_reg, balance_next;
    logic [CNT_W-1:0]              position_reg, position_next;
    logic [CNT_W-1:0]              depth_reg, depth_next;
    logic                          zero_seen_reg, zero_seen_next;
    logic [CNT_W-1:0]              best_reg, best_next;
    logic                          s1_valid_reg;
    stage_t                        s1_reg, s1_next;
    logic                          out_valid_reg;
    lpbi_pkg::out_beat_t           out_reg, out_next;

    // stage 0 and stage 1 signals
    logic                          s_fire;
    logic                          s1_go;
    logic                          ovf0;
    logic signed [BAL_W-1:0]       bal_step;
    logic [CNT_W-1:0]              idx;
    logic [CNT_W:0]                prev;
    logic                          seen_idx;
    logic                          seen_prev;
    logic                          tbl_we;
    logic                          tbl_re;
    logic [FP_W-1:0]               tbl_rdata;
    logic [CNT_W-1:0]              cand_len;

    // handshakes
    assign s1_go     = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || s1_go;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= lpbi_pkg::THRESHOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            threshold_reg <= cfg_data;
        end
    end

    // stage 0: balance step and table addressing
    always_comb begin
        ovf0     = position_reg >= CNT_W'(MAX_LEN);
        bal_step = (s_data.sample > threshold_reg) ? balance_reg + BAL_W'(1)
                                                   : balance_reg - BAL_W'(1);
        idx      = CNT_W'(-bal_step);
        prev     = {1'b0, idx} + (CNT_W+1)'(1);
        seen_idx = (idx == '0) ? zero_seen_reg : (idx <= depth_reg);
        seen_prev = prev <= {1'b0, depth_reg};
    end

    assign tbl_we = s_fire && !ovf0 && (bal_step <= 0) && !seen_idx;
    assign tbl_re = s_fire && !ovf0 && (bal_step <= 0) && seen_prev;

    // stage 0 next state
    always_comb begin
        balance_next   = balance_reg;
        position_next  = position_reg;
        depth_next     = depth_reg;
        zero_seen_next = zero_seen_reg;
        s1_next        = s1_reg;
        if (s_fire) begin
            s1_next.here     = position_reg;
            s1_next.positive = !ovf0 && (bal_step > 0);
            s1_next.lookup   = tbl_re;
            s1_next.overflow = ovf0;
            s1_next.last     = s_data.last;
            if (!ovf0) begin
                balance_next  = bal_step;
                position_next = position_reg + CNT_W'(1);
                if (tbl_we) begin
                    if (idx == '0) begin
                        zero_seen_next = 1'b1;
                    end else begin
                        depth_next = idx;
                    end
                end
            end
            if (s_data.last) begin
                balance_next   = '0;
                position_next  = '0;
                depth_next     = '0;
                zero_seen_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            balance_reg   <= '0;
            position_reg  <= '0;
            depth_reg     <= '0;
            zero_seen_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end else begin
            balance_reg   <= balance_next;
            position_reg  <= position_next;
            depth_reg     <= depth_next;
            zero_seen_reg <= zero_seen_next;
            if (s_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg <= s1_next;
    end

    // first position table, indexed by minus the balance
    lpbi_ram #(
        .WIDTH(FP_W),
        .DEPTH(DEPTH)
    ) u_first_pos (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (idx),
        .wdata (position_reg[FP_W-1:0]),
        .re    (tbl_re),
        .raddr (prev[CNT_W-1:0]),
        .rdata (tbl_rdata)
    );

    // stage 1: best length update
    assign cand_len = s1_reg.here - CNT_W'(tbl_rdata);

    always_comb begin
        best_next = best_reg;
        if (s1_reg.positive) begin
            best_next = s1_reg.here + CNT_W'(1);
        end else if (s1_reg.lookup && (cand_len > best_reg)) begin
            best_next = cand_len;
        end
        out_next.best_length = lpbi_pkg::LEN_W'(best_next);
        out_next.last_out    = s1_reg.last;
        out_next.overflow    = s1_reg.overflow;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_go) begin
                best_reg      <= s1_reg.last ? '0 : best_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (s1_go) begin
            out_reg <= out_next;
        end
    end

endmodule

// File: hw/rtl/lpbi_ram.sv
// lpbi_ram: generic simple dual-port ram, one write port and one registered read port
// read data holds until the next enabled read
// no dependencies
module lpbi_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1025
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/lpbi_checker.sv
// lpbi_checker: port-level assertions for longest_positive_balance_interval
// depends on lpbi_pkg; attached to the top level by the bind at the end of this file
module lpbi_checker #(
    parameter int MAX_LEN = lpbi_pkg::MAX_LEN_DEF
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input lpbi_pkg::out_beat_t m_data
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    // nothing leaves right after reset
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result beat right after reset");

    // an empty output register never blocks new samples
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("sample channel blocked with empty output");

    // reported length never exceeds the sequence limit, checked when MAX_LEN is below 2048
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (MAX_LEN >= 2048) || (32'(m_data.best_length) <= MAX_LEN))
        else $error("best length beyond sequence limit");

    // a sample accepted into an idle block yields a result after the lookup stage and output registers
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid && $past(!m_valid) && $past(!s_valid || !s_ready)
        |-> ##2 m_valid)
        else $error("result missing after accepted sample");

endmodule

bind longest_positive_balance_interval lpbi_checker #(.MAX_LEN(MAX_LEN)) u_lpbi_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for longest_positive_balance_interval
// drives sample beats, writes the threshold register and checks every result beat
// depends on lpbi_pkg and the block's rtl
module tb_top;
    import lpbi_pkg::*;

    localparam int MAX_LEN        = MAX_LEN_DEF;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 300;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_beat_t            s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_beat_t           m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [SAMPLE_W-1:0] cfg_data  = '0;

    // idling controls, percent of cycles
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;

    int err_count   = 0;
    int idle_cycles = 0;

    // predictor state
    logic [SAMPLE_W-1:0] thr_q = THRESHOLD_RESET;
    int                  run_balance = 0;
    int                  seq_pos     = 0;
    int                  best_len    = 0;
    int                  first_pos [0:MAX_LEN];
    bit                  depth_seen [0:MAX_LEN];

    out_beat_t awaited_results [$];
    out_beat_t want;

    longest_positive_balance_interval #(
        .MAX_LEN(MAX_LEN)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // clear the running sequence, first positions stay as they are
    function automatic void clear_interval_state();
        run_balance = 0;
        seq_pos     = 0;
        best_len    = 0;
        foreach (depth_seen[i]) depth_seen[i] = 1'b0;
    endfunction

    // advance the balance by one sample and return the expected result beat
    function automatic out_beat_t advance_interval(in_beat_t b);
        out_beat_t r;
        int        depth;
        int        prev;
        r.overflow = 1'b0;
        if (seq_pos >= MAX_LEN) begin
            r.overflow = 1'b1;
        end else begin
            run_balance += (b.sample > thr_q) ? 1 : -1;
            if (run_balance > 0) begin
                best_len = seq_pos + 1;
            end else begin
                depth = -run_balance;
                prev  = depth + 1;
                if (depth <= MAX_LEN && !depth_seen[depth]) begin
                    depth_seen[depth] = 1'b1;
                    first_pos[depth]  = seq_pos;
                end
                // balance-1 past the table end counts as never reached
                if (prev <= MAX_LEN && depth_seen[prev]) begin
                    if (seq_pos - first_pos[prev] > best_len)
                        best_len = seq_pos - first_pos[prev];
                end
            end
            seq_pos++;
        end
        r.best_length = best_len[LEN_W-1:0];
        r.last_out    = b.last;
        if (b.last)
            clear_interval_state();
        return r;
    endfunction

    // pick a sample on the wanted side of the threshold
    function automatic logic [SAMPLE_W-1:0] pick_sample(bit up);
        int lo;
        if (up && thr_q != 16'hFFFF) begin
            lo = int'(thr_q) + 1;
            case ($urandom_range(3))
                0: return lo[SAMPLE_W-1:0];
                1: return 16'hFFFF;
                default: return SAMPLE_W'($urandom_range(65535, lo));
            endcase
        end
        case ($urandom_range(3))
            0: return thr_q;
            1: return '0;
            default: return SAMPLE_W'($urandom_range(int'(thr_q), 0));
        endcase
    endfunction

    // result side backpressure
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= snk_stall_pct);

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t unexpected result beat: best_length %0d last_out %0b overflow %0b",
                         $time, m_data.best_length, m_data.last_out, m_data.overflow);
                err_count++;
            end else begin
                want = awaited_results.pop_front();
                if (m_data.best_length !== want.best_length) begin
                    $display("%0t best_length mismatch: expected %0d, actual %0d",
                             $time, want.best_length, m_data.best_length);
                    err_count++;
                end
                if (m_data.last_out !== want.last_out) begin
                    $display("%0t last_out mismatch: expected %0b, actual %0b",
                             $time, want.last_out, m_data.last_out);
                    err_count++;
                end
                if (m_data.overflow !== want.overflow) begin
                    $display("%0t overflow mismatch: expected %0b, actual %0b",
                             $time, want.overflow, m_data.overflow);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // send one sample beat, with a random gap in front of it
    task automatic send_sample(logic [SAMPLE_W-1:0] sample, bit last);
        in_beat_t b;
        b.sample = sample;
        b.last   = last;
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < src_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        awaited_results.insert(awaited_results.size(), advance_interval(b));
    endtask

    // stop sending and let every result come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // threshold write, only called with the block drained
    task automatic write_threshold(logic [SAMPLE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        thr_q = value;
    endtask

    task automatic set_idling(int src_pct, int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    // threshold at its reset value, single-beat sequences and a short mix
    task automatic test_reset_threshold();
        set_idling(0, 0);
        send_sample(16'd9, 1'b1);
        send_sample(16'd8, 1'b1);
        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd7, 1'b0);
        send_sample(16'd9, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'd8, 1'b1);
        wait_drained();
    endtask

    // threshold at both ends of its range
    task automatic test_threshold_extremes();
        set_idling(0, 0);
        write_threshold(16'hFFFF);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'h8000, 1'b1);
        wait_drained();
        write_threshold(16'd0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd1, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd0, 1'b1);
        wait_drained();
    endtask

    // full-length sequence: longest result, samples past the limit, then a fresh start
    task automatic test_long_sequence();
        set_idling(37, 37);
        // mostly up up to the limit, then overflow beats with the last on the final one
        write_threshold(SAMPLE_W'($urandom_range(65534)));
        for (int i = 0; i < MAX_LEN + 3; i++)
            send_sample(pick_sample($urandom_range(99) < 90), i == MAX_LEN + 2);
        send_sample(pick_sample(1'b1), 1'b1);
        wait_drained();
    endtask

    // random sequences under one threshold and one idling pattern
    task automatic test_random_phase(int src_pct, int snk_pct,
                                     logic [SAMPLE_W-1:0] thr, int n_items);
        int sent;
        int len;
        int up_pct;
        sent = 0;
        write_threshold(thr);
        set_idling(src_pct, snk_pct);
        while (sent < n_items) begin
            len    = ($urandom_range(99) < 90) ? $urandom_range(24, 1)
                                                : $urandom_range(160, 25);
            up_pct = $urandom_range(90, 10);
            for (int i = 0; i < len; i++)
                send_sample(pick_sample($urandom_range(99) < up_pct), i == len - 1);
            sent += len;
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_threshold();
        test_threshold_extremes();
        test_random_phase(0, 0, SAMPLE_W'($urandom_range(65535)), RANDOM_ITEMS / 4);
        test_random_phase(81, 0, 16'd0, RANDOM_ITEMS / 4);
        test_random_phase(0, 81, SAMPLE_W'($urandom_range(65535)), RANDOM_ITEMS / 4);
        test_random_phase(37, 37, 16'hFFFE, RANDOM_ITEMS / 4);
        test_long_sequence();

        wait_drained();
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: longest_positive_balance_interval.f
hw/rtl/lpbi_pkg.sv
hw/rtl/lpbi_ram.sv
hw/rtl/longest_positive_balance_interval.sv
hw/rtl/lpbi_checker.sv
tb/sv/tb_top.sv
